// ===== hdl/bomb_chain_reachability_unit_assert.svh =====
// assertion macros for the bomb chain reachability unit
`ifndef BOMB_CHAIN_REACHABILITY_UNIT_ASSERT_SVH
`define BOMB_CHAIN_REACHABILITY_UNIT_ASSERT_SVH
`ifndef SYNTH
`define BCR_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define BCR_ASSERT_RESET(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("reset check failed");
`else
`define BCR_ASSERT_IMPL(label, clk, rst_n, prop)
`define BCR_ASSERT_RESET(label, clk, prop)
`endif
`endif

// ===== hdl/bcr_pkg.sv =====
// shared types and constants for the bomb chain reachability unit
`timescale 1ns / 1ps
package bcr_pkg;
    localparam int MAX_BOMBS_DEF = 64;
    localparam int CNT_W = 7;
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_DET  = 2'd1;
    localparam logic [1:0] OP_MAX  = 2'd2;
    localparam logic [1:0] OP_CLR  = 2'd3;
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NF   = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_WALK_INIT, S_CLR_MASK, S_POP,
        S_POP_RD, S_SCAN_RD, S_SCAN_CHK, S_NEXT_START, S_DONE
    } t_state;

    typedef struct packed {
        logic load;        // write bomb at total
        logic clr_total;
        logic srch_init;   // idx <= 0
        logic srch_next;   // idx++
        logic start_set;   // start <= idx for detonate, clears is_max
        logic max_init;
        logic mask_clr;    // clear mask entry at idx, idx++
        logic walk_begin;  // push start, count 1, mark start
        logic pop;         // cur <= stack[top-1]
        logic cur_latch;   // latch cur data
        logic scan_init;   // j <= 0
        logic scan_step;   // evaluate pair, j++
        logic max_next;    // update max, start++
        logic res_nf;
        logic res_cnt;
        logic res_max;
        logic res_zero;
        logic res_full;
        logic rd_idx;      // read store at idx
        logic rd_cur;      // read store at cur
    } t_cmd;

    typedef struct packed {
        logic full;
        logic idx_end;     // idx >= total
        logic match;
        logic stack_empty;
        logic scan_end;
        logic start_end;
        logic is_max;
    } t_stat;
endpackage

// ===== hdl/bcr_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
module bcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== hdl/bcr_ctrl.sv =====
// controller state machine for the bomb chain reachability unit
`timescale 1ns / 1ps
module bcr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_fire,
    input  logic [1:0]     i_opcode,
    input  logic           i_res_free,
    input  bcr_pkg::t_stat i_stat,
    output bcr_pkg::t_cmd  o_cmd,
    output logic           o_idle
);
    bcr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bcr_pkg::S_IDLE: begin
                if (i_in_fire) begin
                    unique case (i_opcode)
                        bcr_pkg::OP_DET: n_state = bcr_pkg::S_SRCH_RD;
                        bcr_pkg::OP_MAX: n_state = bcr_pkg::S_NEXT_START;
                        default:         n_state = bcr_pkg::S_IDLE;
                    endcase
                end
            end
            bcr_pkg::S_SRCH_RD: begin
                if (i_stat.idx_end) begin
                    n_state = bcr_pkg::S_DONE;
                end else begin
                    n_state = bcr_pkg::S_SRCH_CHK;
                end
            end
            bcr_pkg::S_SRCH_CHK: begin
                if (i_stat.match) begin
                    n_state = bcr_pkg::S_WALK_INIT;
                end else begin
                    n_state = bcr_pkg::S_SRCH_RD;
                end
            end
            bcr_pkg::S_NEXT_START: begin
                if (i_stat.start_end) begin
                    n_state = bcr_pkg::S_DONE;
                end else begin
                    n_state = bcr_pkg::S_WALK_INIT;
                end
            end
            bcr_pkg::S_WALK_INIT: n_state = bcr_pkg::S_CLR_MASK;
            bcr_pkg::S_CLR_MASK: begin
                if (i_stat.idx_end) begin
                    n_state = bcr_pkg::S_POP;
                end
            end
            bcr_pkg::S_POP: begin
                if (i_stat.stack_empty) begin
                    n_state = i_stat.is_max ? bcr_pkg::S_NEXT_START : bcr_pkg::S_DONE;
                end else begin
                    n_state = bcr_pkg::S_POP_RD;
                end
            end
            bcr_pkg::S_POP_RD: n_state = bcr_pkg::S_SCAN_RD;
            bcr_pkg::S_SCAN_RD: begin
                if (i_stat.scan_end) begin
                    n_state = bcr_pkg::S_POP;
                end else begin
                    n_state = bcr_pkg::S_SCAN_CHK;
                end
            end
            bcr_pkg::S_SCAN_CHK: n_state = bcr_pkg::S_SCAN_RD;
            bcr_pkg::S_DONE: begin
                if (i_res_free) begin
                    n_state = bcr_pkg::S_IDLE;
                end
            end
            default: n_state = bcr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_idle = 1'b0;
        unique case (r_state)
            bcr_pkg::S_IDLE: begin
                o_idle = 1'b1;
                if (i_in_fire) begin
                    unique case (i_opcode)
                        bcr_pkg::OP_LOAD: begin
                            o_cmd.load     = !i_stat.full;
                            o_cmd.res_full = i_stat.full;
                            o_cmd.res_zero = !i_stat.full;
                        end
                        bcr_pkg::OP_DET: o_cmd.srch_init = 1'b1;
                        bcr_pkg::OP_MAX: o_cmd.max_init  = 1'b1;
                        default: begin
                            o_cmd.clr_total = 1'b1;
                            o_cmd.res_zero  = 1'b1;
                        end
                    endcase
                end
            end
            bcr_pkg::S_SRCH_RD: begin
                o_cmd.rd_idx = 1'b1;
                o_cmd.res_nf = i_stat.idx_end;
            end
            bcr_pkg::S_SRCH_CHK: begin
                o_cmd.start_set = i_stat.match;
                o_cmd.srch_next = !i_stat.match;
            end
            bcr_pkg::S_NEXT_START: o_cmd.res_max = i_stat.start_end;
            bcr_pkg::S_WALK_INIT: o_cmd.srch_init = 1'b1;
            bcr_pkg::S_CLR_MASK: begin
                o_cmd.mask_clr   = 1'b1;
                o_cmd.walk_begin = i_stat.idx_end;
            end
            bcr_pkg::S_POP: begin
                o_cmd.pop      = !i_stat.stack_empty;
                o_cmd.max_next = i_stat.stack_empty && i_stat.is_max;
                o_cmd.res_cnt  = i_stat.stack_empty && !i_stat.is_max;
            end
            bcr_pkg::S_POP_RD: begin
                o_cmd.rd_cur    = 1'b1;
                o_cmd.scan_init = 1'b1;
            end
            bcr_pkg::S_SCAN_RD: begin
                o_cmd.rd_idx    = 1'b1;
                o_cmd.cur_latch = 1'b1;
            end
            bcr_pkg::S_SCAN_CHK: o_cmd.scan_step = 1'b1;
            bcr_pkg::S_DONE: ;
            default: ;
        endcase
    end
endmodule

// ===== hdl/bcr_dp.sv =====
// datapath: bomb stores, visited mask, pending stack and blast test
`timescale 1ns / 1ps
module bcr_dp #(
    parameter int MAX_BOMBS = bcr_pkg::MAX_BOMBS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bcr_pkg::t_cmd              i_cmd,
    input  logic signed [15:0]         i_pos_x,
    input  logic signed [15:0]         i_pos_y,
    input  logic [15:0]                i_radius,
    input  logic                       i_res_take,
    output bcr_pkg::t_stat             o_stat,
    output logic                       o_res_valid,
    output logic [bcr_pkg::CNT_W-1:0]  o_count,
    output logic [1:0]                 o_status
);
    localparam int AW = $clog2(MAX_BOMBS);
    localparam int TW = $clog2(MAX_BOMBS + 1);

    logic [TW-1:0] r_total, r_idx, r_top, r_count, r_max, r_start;
    logic [AW-1:0] r_cur;
    logic [15:0]   r_qx, r_qy, r_cx, r_cy, r_cr;
    logic          r_is_max, r_hit_pend, r_fresh;
    logic          r_res_valid;
    logic [bcr_pkg::CNT_W-1:0] r_res_cnt;
    logic [1:0]    r_res_st;

    logic [AW-1:0] w_addr, w_stk_addr;
    logic [15:0]   w_rx, w_ry, w_rr;
    logic [AW-1:0] w_stk_rd;
    logic          w_stk_we;
    logic [AW-1:0] w_stk_wd;
    logic [AW-1:0] w_idx_a;
    logic          w_hit;
    logic          w_mask_we, w_mask_wd, w_mask_rd;
    logic [AW-1:0] w_mask_addr;

    assign w_idx_a = r_idx[AW-1:0];
    assign w_addr  = i_cmd.load ? r_total[AW-1:0] : (i_cmd.rd_cur ? r_cur : w_idx_a);

    bcr_ram #(.WIDTH(16), .DEPTH(MAX_BOMBS)) u_x (
        .i_clk(i_clk), .i_we(i_cmd.load), .i_addr(w_addr),
        .i_wdata(i_pos_x), .o_rdata(w_rx));
    bcr_ram #(.WIDTH(16), .DEPTH(MAX_BOMBS)) u_y (
        .i_clk(i_clk), .i_we(i_cmd.load), .i_addr(w_addr),
        .i_wdata(i_pos_y), .o_rdata(w_ry));
    bcr_ram #(.WIDTH(16), .DEPTH(MAX_BOMBS)) u_r (
        .i_clk(i_clk), .i_we(i_cmd.load), .i_addr(w_addr),
        .i_wdata(i_radius), .o_rdata(w_rr));

    // pending stack: push on walk start or new hit, read at top-1 on pop
    assign w_stk_we   = i_cmd.walk_begin || (i_cmd.scan_step && w_hit);
    assign w_stk_wd   = i_cmd.walk_begin ? r_start[AW-1:0] : w_idx_a;
    assign w_stk_addr = w_stk_we ? r_top[AW-1:0] : AW'(r_top - TW'(1));
    bcr_ram #(.WIDTH(AW), .DEPTH(MAX_BOMBS)) u_stk (
        .i_clk(i_clk), .i_we(w_stk_we), .i_addr(w_stk_addr),
        .i_wdata(w_stk_wd), .o_rdata(w_stk_rd));

    // visited mask: cleared entry by entry before a walk, read beside the store
    assign w_mask_we   = i_cmd.walk_begin || i_cmd.mask_clr || (i_cmd.scan_step && w_hit);
    assign w_mask_wd   = i_cmd.walk_begin || i_cmd.scan_step;
    assign w_mask_addr = i_cmd.walk_begin ? r_start[AW-1:0] : w_idx_a;
    bcr_ram #(.WIDTH(1), .DEPTH(MAX_BOMBS)) u_mask (
        .i_clk(i_clk), .i_we(w_mask_we), .i_addr(w_mask_addr),
        .i_wdata(w_mask_wd), .o_rdata(w_mask_rd));

    logic [16:0] w_dx, w_dy;
    logic [33:0] w_d2;
    logic [31:0] w_r2;
    always_comb begin
        logic signed [16:0] a, b;
        a = {r_cx[15], r_cx} - {w_rx[15], w_rx};
        b = {r_cy[15], r_cy} - {w_ry[15], w_ry};
        w_dx = a[16] ? 17'(-a) : 17'(a);
        w_dy = b[16] ? 17'(-b) : 17'(b);
        w_d2 = 34'(w_dx * w_dx) + 34'(w_dy * w_dy);
        w_r2 = r_cr * r_cr;
    end
    assign w_hit = !w_mask_rd && (34'(w_r2) >= w_d2);

    assign o_stat.full        = r_total >= TW'(MAX_BOMBS);
    assign o_stat.idx_end     = r_idx >= r_total;
    assign o_stat.match       = (w_rx == r_qx) && (w_ry == r_qy);
    assign o_stat.stack_empty = r_top == '0;
    assign o_stat.scan_end    = r_idx >= r_total;
    assign o_stat.start_end   = r_start >= r_total;
    assign o_stat.is_max      = r_is_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_res_valid <= 1'b0;
            r_top       <= '0;
        end else begin
            if (i_cmd.load) r_total <= r_total + TW'(1);
            if (i_cmd.clr_total) r_total <= '0;
            if (i_res_take) r_res_valid <= 1'b0;
            if (i_cmd.walk_begin) r_top <= TW'(1);
            else if (i_cmd.pop) r_top <= r_top - TW'(1);
            else if (i_cmd.scan_step && w_hit) r_top <= r_top + TW'(1);
            if (i_cmd.res_full || i_cmd.res_zero || i_cmd.res_nf || i_cmd.res_cnt
                    || i_cmd.res_max) begin
                r_res_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_pend <= 1'b0;
        if (i_cmd.srch_init) begin
            r_idx <= '0;
            r_qx  <= i_pos_x;
            r_qy  <= i_pos_y;
        end
        if (i_cmd.max_init) begin
            r_is_max <= 1'b1;
            r_start  <= '0;
            r_max    <= '0;
        end
        if (i_cmd.srch_next) r_idx <= r_idx + TW'(1);
        if (i_cmd.start_set) begin
            r_start  <= r_idx;
            r_is_max <= 1'b0;
        end
        if (i_cmd.walk_begin) begin
            r_count <= TW'(1);
            r_fresh <= 1'b1;
        end else if (i_cmd.mask_clr) begin
            r_idx <= r_idx + TW'(1);
        end
        // the stack read does not yet show the first push, so the first pop takes start
        if (i_cmd.pop) begin
            r_cur   <= r_fresh ? r_start[AW-1:0] : w_stk_rd;
            r_fresh <= 1'b0;
        end
        if (i_cmd.scan_init) r_idx <= '0;
        if (i_cmd.cur_latch && !r_hit_pend) begin
            r_cx <= w_rx;
            r_cy <= w_ry;
            r_cr <= w_rr;
            r_hit_pend <= 1'b1;
        end else if (i_cmd.cur_latch) begin
            r_hit_pend <= 1'b1;
        end
        if (i_cmd.scan_step) begin
            r_hit_pend <= 1'b1;
            r_idx <= r_idx + TW'(1);
            if (w_hit) begin
                r_count <= r_count + TW'(1);
            end
        end
        if (i_cmd.pop) r_hit_pend <= 1'b0;
        if (i_cmd.max_next) begin
            if (r_count > r_max) r_max <= r_count;
            r_start <= r_start + TW'(1);
        end
        if (i_cmd.res_full) begin
            r_res_cnt <= '0;
            r_res_st  <= bcr_pkg::ST_FULL;
        end
        if (i_cmd.res_zero) begin
            r_res_cnt <= '0;
            r_res_st  <= bcr_pkg::ST_OK;
        end
        if (i_cmd.res_nf) begin
            r_res_cnt <= '0;
            r_res_st  <= bcr_pkg::ST_NF;
        end
        if (i_cmd.res_cnt) begin
            r_res_cnt <= bcr_pkg::CNT_W'(r_count);
            r_res_st  <= bcr_pkg::ST_OK;
        end
        if (i_cmd.res_max) begin
            r_res_cnt <= bcr_pkg::CNT_W'(r_max);
            r_res_st  <= bcr_pkg::ST_OK;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_count     = r_res_cnt;
    assign o_status    = r_res_st;
endmodule

// ===== hdl/bomb_chain_reachability_unit.sv =====
// top level of the bomb chain reachability unit
//  channel  dir  fields (low bit up)
//  s_axis   in   tdata: pos_x[15:0] pos_y[31:16] blast_radius[47:32], tuser: opcode
//  m_axis   out  tdata: chain_count[6:0], tuser: status
// load and clear answer straight from idle; detonate searches the table for the
// bomb at pos_x, pos_y, then walks its chain; maximum repeats the walk from every
// bomb as start, with the single store read port scanning one bomb pair at a time
// synchronous active low reset empties the table; no clearing pass
// one beat in flight; the result register holds while m_axis_tready is low
`timescale 1ns / 1ps
`include "bomb_chain_reachability_unit_assert.svh"
module bomb_chain_reachability_unit #(
    parameter int MAX_BOMBS = bcr_pkg::MAX_BOMBS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // pos_x, pos_y, blast_radius
    input  logic [1:0]  s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // chain_count, zero pad
    output logic [1:0]  m_axis_tuser   // status
);
    bcr_pkg::t_cmd  w_cmd;
    bcr_pkg::t_stat w_stat;
    logic w_idle, w_fire, w_rv, w_take;
    logic [bcr_pkg::CNT_W-1:0] w_cnt;

    assign s_axis_tready = w_idle && !w_rv;
    assign w_fire = s_axis_tvalid && s_axis_tready;
    assign w_take = w_rv && m_axis_tready;

    bcr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_fire),
        .i_opcode(s_axis_tuser), .i_res_free(!w_rv), .i_stat(w_stat),
        .o_cmd(w_cmd), .o_idle(w_idle));

    bcr_dp #(.MAX_BOMBS(MAX_BOMBS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_pos_x(s_axis_tdata[15:0]), .i_pos_y(s_axis_tdata[31:16]),
        .i_radius(s_axis_tdata[47:32]), .i_res_take(w_take),
        .o_stat(w_stat), .o_res_valid(w_rv), .o_count(w_cnt),
        .o_status(m_axis_tuser));

    assign m_axis_tvalid = w_rv;
    assign m_axis_tdata  = {1'b0, w_cnt};

    `BCR_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, w_fire |-> w_idle)
    `BCR_ASSERT_IMPL(a_res_holds, i_clk, i_rst_n, (w_rv && !m_axis_tready) |=> w_rv)
    `BCR_ASSERT_IMPL(a_status_legal, i_clk, i_rst_n, w_rv |-> (m_axis_tuser <= bcr_pkg::ST_FULL))
    `BCR_ASSERT_RESET(a_reset_clear, i_clk, !i_rst_n |=> !m_axis_tvalid)
endmodule
